// ===== src/iss_pkg.sv =====
// Shared types and constants for the indexed sequence store.
// Used by iss_ctrl, iss_datapath and indexed_sequence_store; depends on nothing.
`default_nettype none

package iss_pkg;

    localparam int POS_W     = 11;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 11;

    localparam logic signed [VAL_W-1:0] FAIL_READ_VALUE = -32'sd1;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_UNUSED = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_DRAIN,
        S_PLACE,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;       // capture the request fields
        logic start_shift;  // load the shift pointer and its end mark
        logic shift_rd;     // read at the shift pointer and step it
        logic place;        // write the new value at the request position
        logic finish;       // load the result and update the count
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_opcode op;
        logic    req_ok;
        logic    no_shift;
        logic    ptr_at_end;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== src/iss_ctrl.sv =====
// Controller state machine of the indexed sequence store.
// Depends on iss_pkg for the state, opcode and command/status types.
`default_nettype none

module iss_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_valid,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire                       i_ready,
    input  wire iss_pkg::t_dp_status  i_status,
    output iss_pkg::t_dp_cmd          o_cmd
);

    iss_pkg::t_state r_state;
    iss_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iss_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            iss_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = iss_pkg::S_CHECK;
                end
            end
            iss_pkg::S_CHECK: begin
                case (i_status.op)
                    iss_pkg::OP_INSERT: begin
                        if (!i_status.req_ok) begin
                            n_state = iss_pkg::S_DONE;
                        end else if (i_status.no_shift) begin
                            n_state = iss_pkg::S_PLACE;
                        end else begin
                            n_state = iss_pkg::S_SHIFT;
                        end
                    end
                    iss_pkg::OP_REMOVE: begin
                        if (i_status.req_ok && !i_status.no_shift) begin
                            n_state = iss_pkg::S_SHIFT;
                        end else begin
                            n_state = iss_pkg::S_DONE;
                        end
                    end
                    default: n_state = iss_pkg::S_DONE;
                endcase
            end
            iss_pkg::S_SHIFT: begin
                if (i_status.ptr_at_end) begin
                    n_state = iss_pkg::S_DRAIN;
                end
            end
            iss_pkg::S_DRAIN: begin
                if (i_status.op == iss_pkg::OP_INSERT) begin
                    n_state = iss_pkg::S_PLACE;
                end else begin
                    n_state = iss_pkg::S_DONE;
                end
            end
            iss_pkg::S_PLACE: n_state = iss_pkg::S_DONE;
            iss_pkg::S_DONE: begin
                if (slot_free) begin
                    n_state = iss_pkg::S_IDLE;
                end
            end
            default: n_state = iss_pkg::S_IDLE;
        endcase
    end

    // Outputs and commands.
    always_comb begin
        o_cmd             = '0;
        o_ready           = 1'b0;
        n_out_valid       = r_out_valid && !i_ready;
        case (r_state)
            iss_pkg::S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            iss_pkg::S_CHECK: begin
                o_cmd.start_shift = 1'b1;
            end
            iss_pkg::S_SHIFT: begin
                o_cmd.shift_rd = 1'b1;
            end
            iss_pkg::S_PLACE: begin
                o_cmd.place = 1'b1;
            end
            iss_pkg::S_DONE: begin
                o_cmd.finish = slot_free;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== src/iss_datapath.sv =====
// Datapath of the indexed sequence store: entry memory, count, shift pointer, result.
// Depends on iss_pkg for the opcode, command/status types and field widths.
`default_nettype none

module iss_datapath #(
    parameter int CAPACITY = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire iss_pkg::t_dp_cmd                 i_cmd,
    output iss_pkg::t_dp_status                   o_status,
    input  wire  [1:0]                            i_opcode,
    input  wire  [iss_pkg::POS_W-1:0]             i_position,
    input  wire  signed [iss_pkg::VAL_W-1:0]      i_new_value,
    output logic                                  o_ok,
    output logic signed [iss_pkg::VAL_W-1:0]      o_read_value,
    output logic [iss_pkg::CNT_OUT_W-1:0]         o_item_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int WW = (CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic signed [iss_pkg::VAL_W-1:0] r_mem [CAPACITY];

    iss_pkg::t_opcode                 r_op;
    logic [iss_pkg::POS_W-1:0]        r_pos;
    logic signed [iss_pkg::VAL_W-1:0] r_value;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [AW-1:0]                    r_ptr;
    logic [AW-1:0]                    r_end;
    logic                             r_wv;
    logic [AW-1:0]                    r_wa;
    logic signed [iss_pkg::VAL_W-1:0] r_rdata;
    logic [AW-1:0]                    rd_addr;

    logic [WW-1:0] pos_ext;
    logic [WW-1:0] cnt_ext;
    logic [WW-1:0] n_cnt_ext;
    logic [AW-1:0] pos_a;
    logic [AW-1:0] cnt_m1;
    logic          req_ok;
    logic          no_shift;
    logic          is_insert;

    assign pos_ext   = WW'(r_pos);
    assign cnt_ext   = WW'(r_count);
    assign pos_a     = pos_ext[AW-1:0];
    assign cnt_m1    = AW'(r_count - CW'(1));
    assign is_insert = (r_op == iss_pkg::OP_INSERT);

    always_comb begin
        req_ok   = 1'b0;
        no_shift = 1'b0;
        case (r_op)
            iss_pkg::OP_READ: begin
                req_ok = (pos_ext < cnt_ext);
            end
            iss_pkg::OP_INSERT: begin
                req_ok   = (pos_ext <= cnt_ext) && (r_count != CAP_CNT);
                no_shift = (pos_ext == cnt_ext);
            end
            iss_pkg::OP_REMOVE: begin
                req_ok   = (pos_ext < cnt_ext);
                no_shift = ((pos_ext + WW'(1)) == cnt_ext);
            end
            default: req_ok = 1'b0;
        endcase
    end

    assign o_status = '{
        op:         r_op,
        req_ok:     req_ok,
        no_shift:   no_shift,
        ptr_at_end: (r_ptr == r_end)
    };

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= iss_pkg::t_opcode'(i_opcode);
            r_pos   <= i_position;
            r_value <= i_new_value;
        end
    end

    // Shift pointer: inserts walk down from the last entry, removes walk up.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_shift) begin
            if (is_insert) begin
                r_ptr <= cnt_m1;
                r_end <= pos_a;
            end else begin
                r_ptr <= pos_a + AW'(1);
                r_end <= cnt_m1;
            end
        end else if (i_cmd.shift_rd) begin
            r_ptr <= is_insert ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
        end
    end

    // The check cycle reads at the request position for a read request.
    assign rd_addr = i_cmd.shift_rd ? r_ptr : pos_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv <= 1'b0;
        end else begin
            r_wv <= i_cmd.shift_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_rd) begin
            r_wa <= is_insert ? (r_ptr + AW'(1)) : (r_ptr - AW'(1));
        end
    end

    // Entry memory: one write and one registered read each cycle. A moved entry is
    // written back in the cycle after it is read, two addresses away from the next read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_rd || i_cmd.start_shift) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (r_wv) begin
            r_mem[r_wa] <= r_rdata;
        end else if (i_cmd.place) begin
            r_mem[pos_a] <= r_value;
        end
    end

    always_comb begin
        n_count = r_count;
        if (req_ok && is_insert) begin
            n_count = r_count + CW'(1);
        end else if (req_ok && (r_op == iss_pkg::OP_REMOVE)) begin
            n_count = r_count - CW'(1);
        end
    end

    assign n_cnt_ext = WW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.finish) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_ok         <= req_ok;
            o_item_count <= n_cnt_ext[iss_pkg::CNT_OUT_W-1:0];
            if (r_op == iss_pkg::OP_READ) begin
                o_read_value <= req_ok ? r_rdata : iss_pkg::FAIL_READ_VALUE;
            end else begin
                o_read_value <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/indexed_sequence_store.sv =====
// Top level of the indexed sequence store: position-addressed list of signed words.
// Depends on iss_pkg, iss_ctrl and iss_datapath.
//
//   Channel   Handshake            Payload
//   request   i_valid / o_ready    i_opcode, i_position, i_new_value
//   result    o_valid / i_ready    o_ok, o_read_value, o_item_count
//
// One item is worked at a time. A read goes through the check and done states;
// an insert through check, shift and drain (skipped when appending), place and done;
// a remove through check, shift and drain (skipped when it takes the last entry), done.
// The time to move entries is set by the entry memory: one entry is read and one
// written per cycle. A stalled consumer holds back only the final step, in the done state.
// After reset the store is empty; memory contents are not cleared.
`default_nettype none

module indexed_sequence_store #(
    parameter int CAPACITY = 1024
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_valid,
    output logic                                  o_ready,
    input  wire  [1:0]                            i_opcode,
    input  wire  [iss_pkg::POS_W-1:0]             i_position,
    input  wire  signed [iss_pkg::VAL_W-1:0]      i_new_value,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output logic                                  o_ok,
    output logic signed [iss_pkg::VAL_W-1:0]      o_read_value,
    output logic [iss_pkg::CNT_OUT_W-1:0]         o_item_count
);

    iss_pkg::t_dp_cmd    cmd;
    iss_pkg::t_dp_status status;

    // The controller sequences check, shift, place and result; the datapath holds
    // the entries, the count and the result register that the consumer reads.
    iss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    iss_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_opcode     (i_opcode),
        .i_position   (i_position),
        .i_new_value  (i_new_value),
        .o_ok         (o_ok),
        .o_read_value (o_read_value),
        .o_item_count (o_item_count)
    );

endmodule

`default_nettype wire

// ===== test/indexed_sequence_store_tb.sv =====
// Self-checking testbench for indexed_sequence_store: read, insert and remove requests
// checked against a shadow copy of the stored list. Needs only iss_pkg and the block.
// Covers empty and partly filled stores, with random stalls on both channels.
module indexed_sequence_store_tb;

    localparam int POS_W          = iss_pkg::POS_W;
    localparam int VAL_W          = iss_pkg::VAL_W;
    localparam int CNT_OUT_W      = iss_pkg::CNT_OUT_W;
    localparam int STORE_CAPACITY = 1024;
    localparam int IDLE_PERCENT   = 34;
    localparam int RANDOM_ITEMS   = 550;
    // The longest request shifts the whole store, so SETTLE_CYCLES of slack after the
    // last result are enough to catch a stray one.
    localparam int SETTLE_CYCLES  = 16;
    // Worst case is every item shifting a full store behind long stalls; this is
    // several times that bound for the number of items this run sends.
    localparam int CYCLE_LIMIT    = 6_000_000;

    localparam logic signed [VAL_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [POS_W-1:0]        POS_TOP   = '1;

    // One expected result together with the request that caused it.
    typedef struct {
        iss_pkg::t_opcode          op;
        int unsigned               index;
        logic                      ok;
        logic signed [VAL_W-1:0]   read_value;
        logic [CNT_OUT_W-1:0]      item_count;
    } t_store_result;

    // Keeps a shadow copy of the stored list, works out the result of every accepted
    // item and compares the block's results against them in order.
    class t_list_scoreboard;
        logic signed [VAL_W-1:0] shadow_entries[$];
        t_store_result           pending_results[$];
        int unsigned             accepted;
        int unsigned             checked;
        int unsigned             errors;
        int unsigned             peak_count;
        int unsigned             ok_per_op[4];
        int unsigned             failed_per_op[4];

        function int unsigned stored();
            return shadow_entries.size();
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void note_request(iss_pkg::t_opcode op, logic [POS_W-1:0] pos,
                                   logic signed [VAL_W-1:0] value);
            t_store_result r;
            r.op         = op;
            r.index      = accepted;
            r.ok         = 1'b0;
            r.read_value = '0;
            case (op)
                iss_pkg::OP_READ: begin
                    if (pos < shadow_entries.size()) begin
                        r.ok         = 1'b1;
                        r.read_value = shadow_entries[pos];
                    end else begin
                        r.read_value = iss_pkg::FAIL_READ_VALUE;
                    end
                end
                iss_pkg::OP_INSERT: begin
                    if (pos <= shadow_entries.size() &&
                        shadow_entries.size() < STORE_CAPACITY) begin
                        shadow_entries.insert(pos, value);
                        r.ok = 1'b1;
                    end
                end
                iss_pkg::OP_REMOVE: begin
                    if (pos < shadow_entries.size()) begin
                        shadow_entries.delete(pos);
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            r.item_count = CNT_OUT_W'(shadow_entries.size());
            if (r.ok) ok_per_op[op]++;
            else failed_per_op[op]++;
            if (shadow_entries.size() > peak_count) peak_count = shadow_entries.size();
            pending_results.push_back(r);
            accepted++;
        endfunction

        function void check_result(logic ok, logic signed [VAL_W-1:0] read_value,
                                   logic [CNT_OUT_W-1:0] item_count);
            t_store_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing outstanding: ok %0b value %0d count %0d",
                         $time, ok, read_value, item_count);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (ok !== want.ok) begin
                $display("%0t: item %0d (%s) ok: expected %0b, actual %0b",
                         $time, want.index, want.op.name(), want.ok, ok);
                errors++;
            end
            if (read_value !== want.read_value) begin
                $display("%0t: item %0d (%s) read_value: expected %0d, actual %0d",
                         $time, want.index, want.op.name(), want.read_value, read_value);
                errors++;
            end
            if (item_count !== want.item_count) begin
                $display("%0t: item %0d (%s) item_count: expected %0d, actual %0d",
                         $time, want.index, want.op.name(), want.item_count, item_count);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_valid     = 1'b0;
    logic [1:0]               i_opcode    = iss_pkg::OP_READ;
    logic [POS_W-1:0]         i_position  = '0;
    logic signed [VAL_W-1:0]  i_new_value = '0;
    logic                     i_ready     = 1'b0;
    wire                      o_ready;
    wire                      o_valid;
    wire                      o_ok;
    wire signed [VAL_W-1:0]   o_read_value;
    wire [CNT_OUT_W-1:0]      o_item_count;

    // Random idling on both channels is switched off for one long stretch of the run.
    bit                       idle_on     = 1'b1;
    int unsigned              cycle_count = 0;
    t_list_scoreboard         sb          = new();

    indexed_sequence_store #(
        .CAPACITY(STORE_CAPACITY)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_position  (i_position),
        .i_new_value (i_new_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_ok        (o_ok),
        .o_read_value(o_read_value),
        .o_item_count(o_item_count)
    );

    always #6 i_clk = ~i_clk;

    // Result side: the ready line is redrawn every cycle, and a result is taken at
    // every edge where valid and ready were both high just before it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            sb.check_result(o_ok, o_read_value, o_item_count);
        end
        i_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end

    // A hung block ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: no progress after %0d cycles, %0d results outstanding",
                     $time, CYCLE_LIMIT, sb.pending());
            $display("indexed_sequence_store_tb: done, errors");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is accepted. A random gap may
    // come first; valid is only lowered when such a gap is taken, so a following item
    // keeps valid high without a drop in the same time step.
    task automatic send_request(input iss_pkg::t_opcode op, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] value);
        if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < IDLE_PERCENT);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_position  <= pos;
        i_new_value <= value;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        sb.note_request(op, pos, value);
    endtask

    // Holds the request side idle until every outstanding result has been checked.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VAL_W-1:0] random_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 3) return VALUE_MAX;
        if (roll < 6) return VALUE_MIN;
        if (roll < 8) return -1;
        if (roll < 10) return 0;
        return $urandom;
    endfunction

    // Mostly well-formed requests at legal positions, so the list grows and gets
    // shuffled; the rest are boundary and out-of-range positions and unused opcodes.
    task automatic random_request();
        int unsigned            roll;
        int unsigned            count;
        iss_pkg::t_opcode       op;
        logic [POS_W-1:0]       pos;
        count = sb.stored();
        roll  = $urandom_range(99);
        if (roll < 45) op = iss_pkg::OP_INSERT;
        else if (roll < 70) op = iss_pkg::OP_READ;
        else if (roll < 96) op = iss_pkg::OP_REMOVE;
        else op = iss_pkg::OP_UNUSED;
        roll = $urandom_range(99);
        if (roll < 85) begin
            if (op == iss_pkg::OP_INSERT) pos = POS_W'($urandom_range(count));
            else pos = (count == 0) ? '0 : POS_W'($urandom_range(count - 1));
        end else if (roll < 92) begin
            pos = POS_W'(count);
        end else begin
            pos = POS_W'($urandom_range(POS_TOP));
        end
        send_request(op, pos, random_value());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty store: every request fails, and an insert is only taken at position 0.
        send_request(iss_pkg::OP_READ,   '0,       $urandom);
        send_request(iss_pkg::OP_REMOVE, '0,       $urandom);
        send_request(iss_pkg::OP_INSERT, 11'd1,    VALUE_MAX);
        send_request(iss_pkg::OP_INSERT, POS_TOP,  VALUE_MAX);
        send_request(iss_pkg::OP_UNUSED, POS_TOP,  $urandom);
        // Build a short list with the value extremes, using front, end and middle inserts.
        send_request(iss_pkg::OP_INSERT, '0,       VALUE_MAX);
        send_request(iss_pkg::OP_INSERT, 11'd1,    VALUE_MIN);
        send_request(iss_pkg::OP_INSERT, '0,       -1);
        send_request(iss_pkg::OP_INSERT, 11'd2,    '0);
        send_request(iss_pkg::OP_INSERT, 11'd6,    $urandom);
        send_request(iss_pkg::OP_UNUSED, '0,       $urandom);
        send_request(iss_pkg::OP_READ,   '0,       $urandom);
        send_request(iss_pkg::OP_READ,   11'd1,    $urandom);
        send_request(iss_pkg::OP_READ,   11'd2,    $urandom);
        send_request(iss_pkg::OP_READ,   11'd3,    $urandom);
        send_request(iss_pkg::OP_READ,   11'd4,    $urandom);
        send_request(iss_pkg::OP_READ,   POS_TOP,  $urandom);
        // Removes out of range, from the middle, at the end and at the front.
        send_request(iss_pkg::OP_REMOVE, 11'd4,    $urandom);
        send_request(iss_pkg::OP_REMOVE, POS_TOP,  $urandom);
        send_request(iss_pkg::OP_REMOVE, 11'd1,    $urandom);
        send_request(iss_pkg::OP_REMOVE, 11'd2,    $urandom);
        send_request(iss_pkg::OP_REMOVE, '0,       $urandom);
        send_request(iss_pkg::OP_READ,   '0,       $urandom);
        wait_for_results();

        // Random part, with one long calm stretch and one pause for the results.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = !(n >= 200 && n < 330);
            if (n == 400) wait_for_results();
            random_request();
        end
        idle_on = 1'b1;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: reads %0d ok/%0d failed, inserts %0d/%0d,",
                 sb.checked, sb.ok_per_op[iss_pkg::OP_READ],
                 sb.failed_per_op[iss_pkg::OP_READ],
                 sb.ok_per_op[iss_pkg::OP_INSERT], sb.failed_per_op[iss_pkg::OP_INSERT]);
        $display("removes %0d/%0d, %0d unused-opcode requests; peak %0d of %0d entries.",
                 sb.ok_per_op[iss_pkg::OP_REMOVE], sb.failed_per_op[iss_pkg::OP_REMOVE],
                 sb.failed_per_op[iss_pkg::OP_UNUSED], sb.peak_count, STORE_CAPACITY);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("indexed_sequence_store_tb: done, clean");
        end else begin
            $display("indexed_sequence_store_tb: done, errors");
        end
        $finish;
    end
endmodule
